@@ hw/rtl/odo_pkg.sv @@
// ----------------------------------------------------------------------------
// odo_pkg
// shared types, constants and the cordic arctangent table for the odometry unit
// ----------------------------------------------------------------------------
package odo_pkg;

  localparam int unsigned CordicStepsDefault = 24;

  // configuration reset values
  localparam logic [31:0] MptReset  = 32'd966899;
  localparam logic [30:0] TptdReset = 31'd1719395;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_METERS_PER_TICK = 2'd0,
    CFG_TURN_PER_TICK   = 2'd1
  } cfg_idx_e;

  // cordic datapath, signed q30 with headroom
  localparam int unsigned CordW = 34;
  localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [CordW-1:0] Q30One     = 34'sd1073741824;

  // queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // atan(2^-i) as binary angle, 2^32 per turn
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] val;
    begin
      case (idx)
        5'd0:    val = 32'd536870912;
        5'd1:    val = 32'd316933406;
        5'd2:    val = 32'd167458907;
        5'd3:    val = 32'd85004756;
        5'd4:    val = 32'd42667331;
        5'd5:    val = 32'd21354465;
        5'd6:    val = 32'd10679838;
        5'd7:    val = 32'd5340245;
        5'd8:    val = 32'd2670163;
        5'd9:    val = 32'd1335087;
        5'd10:   val = 32'd667544;
        5'd11:   val = 32'd333772;
        5'd12:   val = 32'd166886;
        5'd13:   val = 32'd83443;
        5'd14:   val = 32'd41722;
        5'd15:   val = 32'd20861;
        5'd16:   val = 32'd10430;
        5'd17:   val = 32'd5215;
        5'd18:   val = 32'd2608;
        5'd19:   val = 32'd1304;
        5'd20:   val = 32'd652;
        5'd21:   val = 32'd326;
        5'd22:   val = 32'd163;
        5'd23:   val = 32'd81;
        5'd24:   val = 32'd41;
        5'd25:   val = 32'd20;
        5'd26:   val = 32'd10;
        5'd27:   val = 32'd5;
        5'd28:   val = 32'd3;
        5'd29:   val = 32'd1;
        5'd30:   val = 32'd1;
        default: val = 32'd0;
      endcase
      return val;
    end
  endfunction

  // classified item handed from front to back
  typedef struct packed {
    logic signed [32:0] tick_sum;   // left delta plus right delta
    logic [31:0]        tick_diff;  // right delta minus left delta, mod 2^32
  } odo_item_t;

  // cordic result bundle
  typedef struct packed {
    logic               done;
    logic signed [31:0] cos_val;
    logic signed [31:0] sin_val;
  } odo_trig_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD,
    ST_DIST,
    ST_ROT,
    ST_MLO,
    ST_MHI,
    ST_STEP,
    ST_ACC,
    ST_DONE
  } odo_state_e;

endpackage

@@ hw/rtl/odo_in_if.sv @@
// ----------------------------------------------------------------------------
// odo_in_if
// encoder count channel: valid/ready with left and right absolute counts
// ----------------------------------------------------------------------------
interface odo_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;

  modport source (output valid, left_count, right_count, input ready);
  modport sink   (input valid, left_count, right_count, output ready);
endinterface

@@ hw/rtl/odo_out_if.sv @@
// ----------------------------------------------------------------------------
// odo_out_if
// pose channel: valid/ready with x, y position and heading
// ----------------------------------------------------------------------------
interface odo_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] pos_x;
  logic signed [47:0] pos_y;
  logic signed [31:0] heading;

  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

@@ hw/rtl/odo_front.sv @@
// ----------------------------------------------------------------------------
// odo_front
// takes encoder counts, forms wrap-safe tick deltas, keeps the previous counts
// ----------------------------------------------------------------------------
module odo_front import odo_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  odo_in_if.sink     in_i,
  input  logic       full_i,
  output logic       push_o,
  output odo_item_t  item_o
);

  logic [31:0] prev_left_q, prev_right_q;
  logic [31:0] dl, dr;

  assign dl = in_i.left_count - prev_left_q;
  assign dr = in_i.right_count - prev_right_q;

  assign in_i.ready       = !full_i;
  assign push_o           = in_i.valid && !full_i;
  assign item_o.tick_sum  = {dl[31], dl} + {dr[31], dr};
  assign item_o.tick_diff = dr - dl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_left_q  <= '0;
      prev_right_q <= '0;
    end else if (push_o) begin
      prev_left_q  <= in_i.left_count;
      prev_right_q <= in_i.right_count;
    end
  end

endmodule

@@ hw/rtl/odo_queue.sv @@
// ----------------------------------------------------------------------------
// odo_queue
// short fifo between front and back so each side stalls on its own
// ----------------------------------------------------------------------------
module odo_queue import odo_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  odo_item_t item_i,
  input  logic      pop_i,
  output odo_item_t item_o,
  output logic      full_o,
  output logic      empty_o
);

  odo_item_t             mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_q, rd_q;
  logic [QueuePtrW:0]    cnt_q;

  assign full_o  = (cnt_q == (QueuePtrW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");

endmodule

@@ hw/rtl/odo_cordic.sv @@
// ----------------------------------------------------------------------------
// odo_cordic
// iterative rotation-mode cordic, one micro-rotation per cycle
// ----------------------------------------------------------------------------
module odo_cordic import odo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CordicStepsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] angle_i,
  output odo_trig_t   trig_o
);

  localparam int unsigned IdxW = $clog2(CORDIC_STEPS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CORDIC_STEPS - 1);

  logic signed [CordW-1:0] x_q, y_q, z_q;
  logic signed [CordW-1:0] dx, dy, at, x_n, y_n, z_n, xf, yf;
  logic [IdxW-1:0]         idx_q;
  logic                    busy_q, fin_q, done_q, flip_q;
  logic signed [31:0]      cos_q, sin_q;
  logic                    flip_st;
  logic [31:0]             ang_st;

  function automatic logic signed [31:0] clamp_unit(input logic signed [CordW-1:0] v);
    logic signed [CordW-1:0] r;
    begin
      if (v > Q30One) begin
        r = Q30One;
      end else if (v < -Q30One) begin
        r = -Q30One;
      end else begin
        r = v;
      end
      return r[31:0];
    end
  endfunction

  // angles beyond +-pi/2 rotate by pi first, result negated at the end
  assign flip_st = angle_i[31] ^ angle_i[30];
  assign ang_st  = {angle_i[31] ^ flip_st, angle_i[30:0]};

  assign dx = y_q >>> idx_q;
  assign dy = x_q >>> idx_q;
  assign at = CordW'(atan_lut(5'(idx_q)));

  always_comb begin
    if (!z_q[CordW-1]) begin
      x_n = x_q - dx;
      y_n = y_q + dy;
      z_n = z_q - at;
    end else begin
      x_n = x_q + dx;
      y_n = y_q - dy;
      z_n = z_q + at;
    end
  end

  assign xf = flip_q ? -x_q : x_q;
  assign yf = flip_q ? -y_q : y_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CordicGain;
      y_q    <= '0;
      z_q    <= {{(CordW-32){ang_st[31]}}, ang_st};
      flip_q <= flip_st;
    end else if (busy_q) begin
      x_q <= x_n;
      y_q <= y_n;
      z_q <= z_n;
    end
    if (fin_q) begin
      cos_q <= clamp_unit(xf);
      sin_q <= clamp_unit(yf);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (busy_q) begin
        if (idx_q == LastIdx) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  assign trig_o.done    = done_q;
  assign trig_o.cos_val = cos_q;
  assign trig_o.sin_val = sin_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && !fin_q) else $error("cordic done while still rotating");

endmodule

@@ hw/rtl/odo_back.sv @@
// ----------------------------------------------------------------------------
// odo_back
// sequencer: heading and distance products, cordic, axis steps, saturation
// ----------------------------------------------------------------------------
module odo_back import odo_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  odo_item_t   q_item_i,
  input  logic        q_empty_i,
  output logic        q_pop_o,
  input  logic [31:0] mpt_i,
  input  logic [30:0] tptd_i,
  input  odo_trig_t   trig_i,
  output logic        cordic_start_o,
  output logic [31:0] cordic_angle_o,
  odo_out_if.source   out_o
);

  odo_state_e state_q, state_d;

  logic [31:0]        diff_q, heading_q, out_heading_q;
  logic [32:0]        mag_q;
  logic               neg_q, axis_q;
  logic [63:0]        prod_q, dist_q, lo_q, step_r;
  logic [30:0]        cmag_q, smag_q, tmag;
  logic               cneg_q, sneg_q, tneg;
  logic [48:0]        step_mag_q;
  logic               step_neg_q;
  logic signed [47:0] acc_x_q, acc_y_q, out_x_q, out_y_q, acc_new;
  logic signed [49:0] acc_ext, step_ext, acc_sum;
  logic               out_valid_q, out_load;
  logic               mul_en;
  logic [31:0]        mul_a, mul_b;
  logic signed [32:0] item_sum;
  logic [63:0]        dist_sum;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (!q_empty_i) state_d = ST_HEAD;
      ST_HEAD: state_d = ST_DIST;
      ST_DIST: state_d = ST_ROT;
      ST_ROT:  if (trig_i.done) state_d = ST_MLO;
      ST_MLO:  state_d = ST_MHI;
      ST_MHI:  state_d = ST_STEP;
      ST_STEP: state_d = ST_ACC;
      ST_ACC:  state_d = axis_q ? ST_DONE : ST_MLO;
      ST_DONE: if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign tmag = axis_q ? smag_q : cmag_q;
  assign tneg = axis_q ? sneg_q : cneg_q;

  // outputs and shared multiplier operands
  always_comb begin
    q_pop_o        = 1'b0;
    cordic_start_o = 1'b0;
    out_load       = 1'b0;
    mul_en         = 1'b0;
    mul_a          = '0;
    mul_b          = '0;
    unique case (state_q)
      ST_IDLE: q_pop_o = !q_empty_i;
      ST_HEAD: begin
        mul_en = 1'b1;
        mul_a  = diff_q;
        mul_b  = {1'b0, tptd_i};
      end
      ST_DIST: begin
        mul_en         = 1'b1;
        mul_a          = mag_q[31:0];
        mul_b          = mpt_i;
        cordic_start_o = 1'b1;
      end
      ST_MLO: begin
        mul_en = 1'b1;
        mul_a  = dist_q[31:0];
        mul_b  = {1'b0, tmag};
      end
      ST_MHI: begin
        mul_en = 1'b1;
        mul_a  = dist_q[63:32];
        mul_b  = {1'b0, tmag};
      end
      ST_DONE: out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  assign cordic_angle_o = heading_q + prod_q[31:0];
  assign item_sum       = q_item_i.tick_sum;

  // full magnitude 2^32 only shows up with a zero low word
  assign dist_sum = prod_q + (mag_q[32] ? {mpt_i, 32'd0} : 64'd0);

  // axis step magnitude before clamping
  assign step_r = {prod_q[61:0], 2'b00} + {30'd0, lo_q[63:30]};

  // accumulate with saturation at the 48-bit limits
  assign acc_ext  = axis_q ? {{2{acc_y_q[47]}}, acc_y_q} : {{2{acc_x_q[47]}}, acc_x_q};
  assign step_ext = step_neg_q ? -{1'b0, step_mag_q} : {1'b0, step_mag_q};
  assign acc_sum  = acc_ext + step_ext;

  always_comb begin
    if (acc_sum[49:47] == 3'b000 || acc_sum[49:47] == 3'b111) begin
      acc_new = acc_sum[47:0];
    end else if (acc_sum[49]) begin
      acc_new = {1'b1, 47'd0};
    end else begin
      acc_new = {1'b0, {47{1'b1}}};
    end
  end

  // datapath without reset
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    unique case (state_q)
      ST_IDLE: begin
        diff_q <= q_item_i.tick_diff;
        neg_q  <= item_sum[32];
        mag_q  <= item_sum[32] ? 33'(-item_sum) : 33'(item_sum);
      end
      ST_ROT: begin
        dist_q <= dist_sum >> 1;
        if (trig_i.done) begin
          cneg_q <= trig_i.cos_val[31];
          cmag_q <= trig_i.cos_val[31] ? 31'(-trig_i.cos_val) : trig_i.cos_val[30:0];
          sneg_q <= trig_i.sin_val[31];
          smag_q <= trig_i.sin_val[31] ? 31'(-trig_i.sin_val) : trig_i.sin_val[30:0];
        end
      end
      ST_MHI: lo_q <= prod_q;
      ST_STEP: begin
        step_neg_q <= neg_q ^ tneg;
        if (|step_r[63:49] || (step_r[48] && |step_r[47:0])) begin
          step_mag_q <= {1'b1, 48'd0};
        end else begin
          step_mag_q <= step_r[48:0];
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_x_q       <= acc_x_q;
      out_y_q       <= acc_y_q;
      out_heading_q <= heading_q;
    end
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      heading_q   <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DIST) begin
        heading_q <= heading_q + prod_q[31:0];
      end
      if (state_q == ST_ROT) begin
        axis_q <= 1'b0;
      end
      if (state_q == ST_ACC) begin
        if (axis_q) begin
          acc_y_q <= acc_new;
        end else begin
          acc_x_q <= acc_new;
          axis_q  <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.pos_x   = out_x_q;
  assign out_o.pos_y   = out_y_q;
  assign out_o.heading = out_heading_q;

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE)) else $error("result without done state");
  a_trig_in_rot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig_i.done |-> state_q == ST_ROT) else $error("cordic result outside rotate state");

endmodule

@@ hw/rtl/diff_drive_wheel_odometry_unit.sv @@
// ----------------------------------------------------------------------------
// diff_drive_wheel_odometry_unit
// differential drive wheel odometry: encoder counts in, saturating pose out
// ----------------------------------------------------------------------------
// the back end finishes one item before it pops the next, paced by the
//   iterative cordic and the one shared 32x32 multiplier
// a second item can wait in the two-entry queue while one is in the back end
// reset: async active low; counts, pose and heading clear to zero, registers
//   return to their default scale values
module diff_drive_wheel_odometry_unit import odo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CordicStepsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // encoder count channel
  odo_in_if.sink              in_i,
  // pose channel
  odo_out_if.source           out_o
);

  // scale registers
  logic [31:0] mpt_q;
  logic [30:0] tptd_q;

  // front to queue
  logic      push, q_full;
  odo_item_t push_item;

  // queue to back
  logic      pop, q_empty;
  odo_item_t head_item;

  // back to cordic and back
  logic        cordic_start;
  logic [31:0] cordic_angle;
  odo_trig_t   trig;

  // writes to unused indices are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpt_q  <= MptReset;
      tptd_q <= TptdReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_METERS_PER_TICK: mpt_q  <= cfg_data_i[31:0];
        CFG_TURN_PER_TICK:   tptd_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // front: tick deltas and previous counts
  odo_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (q_full),
    .push_o (push),
    .item_o (push_item)
  );

  // decoupling queue
  odo_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // cos and sin of the updated heading
  odo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (cordic_angle),
    .trig_o  (trig)
  );

  // back: heading, distance, axis steps and the result register
  odo_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_item_i       (head_item),
    .q_empty_i      (q_empty),
    .q_pop_o        (pop),
    .mpt_i          (mpt_q),
    .tptd_i         (tptd_q),
    .trig_i         (trig),
    .cordic_start_o (cordic_start),
    .cordic_angle_o (cordic_angle),
    .out_o          (out_o)
  );

  // a pop always leaves at least one free queue slot behind it
  a_pop_frees_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> !q_full) else $error("queue still full after pop");

endmodule
